// ===== rtl/core/bbs_pkg.sv =====
package bbs_pkg;

  // field widths
  localparam int unsigned CoordW   = 32;
  localparam int unsigned InDataW  = 6 * CoordW;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 7 * CoordW;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned RemW     = CoordW + 2;

  // isqrt runs one result bit per cycle
  localparam int unsigned RootSteps = CoordW;
  localparam int unsigned RootCntW  = $clog2(RootSteps);

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_e;

  // box bounds, min_x in the lowest bits
  typedef struct packed {
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_x;
  } box_t;

  // one queue slot with its valid flag
  typedef struct packed {
    logic valid;
    box_t box;
  } slot_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXTENT,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } back_state_e;

endpackage

// ===== rtl/core/bbs_front.sv =====
module bbs_front import bbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [InDataW-1:0] s_tdata_i,  // coord_x, coord_y, coord_z, upper_x, upper_y, upper_z
  input  logic [InUserW-1:0] s_tuser_i,  // cmd[1:0], first_point
  input  logic               s_tlast_i,  // last_point
  input  logic               full_i,
  output slot_t              push_o
);

  box_t box_q, box_d;
  logic produce;
  logic accept;
  cmd_e cmd;
  logic first;
  logic signed [CoordW-1:0] px, py, pz, ux, uy, uz;

  // field unpacking
  assign px    = $signed(s_tdata_i[0*CoordW +: CoordW]);
  assign py    = $signed(s_tdata_i[1*CoordW +: CoordW]);
  assign pz    = $signed(s_tdata_i[2*CoordW +: CoordW]);
  assign ux    = $signed(s_tdata_i[3*CoordW +: CoordW]);
  assign uy    = $signed(s_tdata_i[4*CoordW +: CoordW]);
  assign uz    = $signed(s_tdata_i[5*CoordW +: CoordW]);
  assign cmd   = cmd_e'(s_tuser_i[1:0]);
  assign first = s_tuser_i[2];

  assign s_tready_o = ~full_i;
  assign accept     = s_tvalid_i & s_tready_o;

  // bounds update and result decision
  always_comb begin
    box_d   = box_q;
    produce = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (first) begin
          box_d.min_x = px;
          box_d.min_y = py;
          box_d.min_z = pz;
          box_d.max_x = px;
          box_d.max_y = py;
          box_d.max_z = pz;
        end else begin
          box_d.min_x = (px < box_q.min_x) ? px : box_q.min_x;
          box_d.min_y = (py < box_q.min_y) ? py : box_q.min_y;
          box_d.min_z = (pz < box_q.min_z) ? pz : box_q.min_z;
          box_d.max_x = (px > box_q.max_x) ? px : box_q.max_x;
          box_d.max_y = (py > box_q.max_y) ? py : box_q.max_y;
          box_d.max_z = (pz > box_q.max_z) ? pz : box_q.max_z;
        end
        produce = s_tlast_i;
      end
      CMD_LOAD: begin
        box_d.min_x = px;
        box_d.min_y = py;
        box_d.min_z = pz;
        box_d.max_x = ux;
        box_d.max_y = uy;
        box_d.max_z = uz;
        produce     = 1'b1;
      end
      CMD_EMPTY: begin
        box_d   = '0;
        produce = 1'b1;
      end
      default: begin
        box_d   = box_q;
        produce = 1'b0;
      end
    endcase
  end

  // running bounds, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (accept) begin
      box_q <= box_d;
    end
  end

  // snapshot goes to the queue on a result-producing transfer
  assign push_o.valid = accept & produce;
  assign push_o.box   = box_d;

endmodule

// ===== rtl/core/bbs_queue.sv =====
module bbs_queue import bbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  slot_t push_i,
  output logic  full_o,
  output slot_t head_o,
  input  logic  pop_i
);

  box_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.box   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.box;
    end
  end

endmodule

// ===== rtl/core/bbs_back.sv =====
module bbs_back import bbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slot_t               head_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o  // box_min_x/y/z, box_max_x/y/z, half_diagonal
);

  back_state_e state_q, state_d;

  box_t                  box_q, box_d;
  logic [2:0][CoordW-1:0] ext_q, ext_d;
  logic [1:0]            sq_cnt_q, sq_cnt_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [ProdW-1:0]      op_q, op_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [CoordW-1:0]     root_q, root_d;
  logic [RootCntW-1:0]   rt_cnt_q, rt_cnt_d;

  logic [CoordW-1:0] ext_sel;
  logic [RemW+1:0]   rem_sh;
  logic [RemW+1:0]   trial;

  // magnitude of one extent, fits 32 bits
  function automatic logic [CoordW-1:0] abs_ext(logic signed [CoordW-1:0] hi,
                                                logic signed [CoordW-1:0] lo);
    logic signed [CoordW:0] d;
    logic signed [CoordW:0] n;
    d = (CoordW+1)'(hi) - (CoordW+1)'(lo);
    n = -d;
    return d[CoordW] ? n[CoordW-1:0] : d[CoordW-1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (head_i.valid) state_d = ST_EXTENT;
      ST_EXTENT: state_d = ST_SQUARE;
      ST_SQUARE: if (sq_cnt_q == 2'd3) state_d = ST_ROOT;
      ST_ROOT:   if (rt_cnt_q == RootCntW'(RootSteps - 1)) state_d = ST_OUT;
      ST_OUT:    if (m_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop_o      = 1'b0;
    m_tvalid_o = 1'b0;
    case (state_q)
      ST_IDLE: pop_o      = head_i.valid;
      ST_OUT:  m_tvalid_o = 1'b1;
      default: begin
        pop_o      = 1'b0;
        m_tvalid_o = 1'b0;
      end
    endcase
  end

  // shared squarer operand
  always_comb begin
    case (sq_cnt_q)
      2'd0:    ext_sel = ext_q[0];
      2'd1:    ext_sel = ext_q[1];
      2'd2:    ext_sel = ext_q[2];
      default: ext_sel = '0;
    endcase
  end

  // one root digit: shift in two operand bits, try subtract
  assign rem_sh = {rem_q, op_q[ProdW-1 -: 2]};
  assign trial  = (RemW+2)'({root_q, 2'b01});

  // datapath
  always_comb begin
    box_d    = box_q;
    ext_d    = ext_q;
    sq_cnt_d = sq_cnt_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    op_d     = op_q;
    rem_d    = rem_q;
    root_d   = root_q;
    rt_cnt_d = rt_cnt_q;
    case (state_q)
      ST_IDLE: begin
        box_d = head_i.box;
      end
      ST_EXTENT: begin
        ext_d[0] = abs_ext(box_q.max_x, box_q.min_x);
        ext_d[1] = abs_ext(box_q.max_y, box_q.min_y);
        ext_d[2] = abs_ext(box_q.max_z, box_q.min_z);
        acc_d    = '0;
        sq_cnt_d = 2'd0;
      end
      ST_SQUARE: begin
        prod_d   = ProdW'(ext_sel) * ProdW'(ext_sel);
        sq_cnt_d = sq_cnt_q + 2'd1;
        if (sq_cnt_q != 2'd0) begin
          acc_d = acc_q + AccW'(prod_q);
        end
        if (sq_cnt_q == 2'd3) begin
          op_d     = acc_d[AccW-1:2];
          rem_d    = '0;
          root_d   = '0;
          rt_cnt_d = '0;
        end
      end
      ST_ROOT: begin
        op_d     = {op_q[ProdW-3:0], 2'b00};
        rt_cnt_d = rt_cnt_q + RootCntW'(1);
        if (rem_sh >= trial) begin
          rem_d  = RemW'(rem_sh - trial);
          root_d = {root_q[CoordW-2:0], 1'b1};
        end else begin
          rem_d  = RemW'(rem_sh);
          root_d = {root_q[CoordW-2:0], 1'b0};
        end
      end
      default: begin
        box_d = box_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sq_cnt_q <= 2'd0;
      rt_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      sq_cnt_q <= sq_cnt_d;
      rt_cnt_q <= rt_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    box_q  <= box_d;
    ext_q  <= ext_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // result stays registered in the final state until taken
  assign m_tdata_o = {root_q, box_q};

endmodule

// ===== rtl/core/bounding_box_and_sphere.sv =====
// an input transfer that ends a set pushes its box into the queue; the back
// end, when free, takes it through extent, shared squarer and bit-serial
// square root to the output register, where the result waits until taken.
// throughput: one point per cycle while the two-entry box queue between
// front and back end is not full; the back end handles one box at a time.
// reset: asynchronous, active low; clears bounds to zero and empties the queue.
module bounding_box_and_sphere import bbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // coord_x, coord_y, coord_z, upper_x, upper_y, upper_z
  input  logic [InUserW-1:0]  s_axis_tuser_i,  // cmd[1:0], first_point
  input  logic                s_axis_tlast_i,  // last_point
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // box_min_x/y/z, box_max_x/y/z, half_diagonal
);

  slot_t push;
  slot_t head;
  logic  full;
  logic  pop;

  // bounds tracking
  bbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tlast_i  (s_axis_tlast_i),
    .full_i     (full),
    .push_o     (push)
  );

  // box queue
  bbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // radius unit and output register
  bbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.valid |-> !full)
    else $error("push into full box queue");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid)
    else $error("pop from empty box queue");

  // a degenerate box has zero radius
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o &&
     m_axis_tdata_o[0*CoordW +: CoordW] == m_axis_tdata_o[3*CoordW +: CoordW] &&
     m_axis_tdata_o[1*CoordW +: CoordW] == m_axis_tdata_o[4*CoordW +: CoordW] &&
     m_axis_tdata_o[2*CoordW +: CoordW] == m_axis_tdata_o[5*CoordW +: CoordW])
    |-> (m_axis_tdata_o[6*CoordW +: CoordW] == '0))
    else $error("nonzero radius for a point box");

endmodule

// ===== dv/bounding_box_and_sphere_checker.sv =====
module bounding_box_and_sphere_checker import bbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // coord_x, coord_y, coord_z, upper_x, upper_y, upper_z
  input  logic [InUserW-1:0]  s_axis_tuser_i,  // cmd[1:0], first_point
  input  logic                s_axis_tlast_i,  // last_point
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,  // box_min_x/y/z, box_max_x/y/z, half_diagonal
  input  logic                drain_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumFields = 7;
  localparam int MaxShown  = 10;

  string field_names [NumFields] = '{"box_min_x", "box_min_y", "box_min_z",
                                     "box_max_x", "box_max_y", "box_max_z",
                                     "half_diagonal"};

  box_t                bounds;
  logic [OutDataW-1:0] expected_boxes_q [$];
  int                  fails;
  int                  shown;
  int                  results_seen;
  bit                  drained;

  // floor of the square root, one result bit per step
  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    logic [63:0] sq;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c  = r | (32'd1 << b);
      sq = {32'd0, c} * {32'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  // square of one extent, exact over 33 bits
  function automatic logic [63:0] extent_square(input logic [31:0] hi, input logic [31:0] lo);
    logic signed [32:0] d;
    logic [31:0]        mag;
    d = {hi[31], hi} - {lo[31], lo};
    if (d[32]) d = -d;
    mag = d[31:0];
    return {32'd0, mag} * {32'd0, mag};
  endfunction

  // box word with half its diagonal on top
  function automatic logic [OutDataW-1:0] box_result(input box_t b);
    logic [65:0] sum;
    sum = {2'b00, extent_square(b.max_x, b.min_x)}
        + {2'b00, extent_square(b.max_y, b.min_y)}
        + {2'b00, extent_square(b.max_z, b.min_z)};
    return {floor_root(sum[65:2]), b};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutDataW-1:0] exp_word;
    logic signed [31:0]  px, py, pz;
    logic [1:0]          cmd;
    if (!rst_ni) begin
      bounds = '0;
      expected_boxes_q.delete();
      fails        = 0;
      shown        = 0;
      results_seen = 0;
      drained      = 1'b0;
    end else begin
      // output transfer against the oldest expected box
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_seen++;
        if (expected_boxes_q.size() == 0) begin
          fails++;
          if (shown < MaxShown) begin
            shown++;
            $display("%0t: unexpected result %h", $realtime, m_axis_tdata_i);
          end
        end else begin
          exp_word = expected_boxes_q.pop_front();
          for (int f = 0; f < NumFields; f++) begin
            if (m_axis_tdata_i[f*CoordW +: CoordW] !== exp_word[f*CoordW +: CoordW]) begin
              fails++;
              if (shown < MaxShown) begin
                shown++;
                $display("%0t: result %0d %s expected %h got %h", $realtime, results_seen,
                         field_names[f], exp_word[f*CoordW +: CoordW],
                         m_axis_tdata_i[f*CoordW +: CoordW]);
              end
            end
          end
        end
      end

      // input transfer updates the tracked bounds
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        cmd = s_axis_tuser_i[1:0];
        px  = s_axis_tdata_i[0*CoordW +: CoordW];
        py  = s_axis_tdata_i[1*CoordW +: CoordW];
        pz  = s_axis_tdata_i[2*CoordW +: CoordW];
        case (cmd)
          CMD_ADD: begin
            if (s_axis_tuser_i[2]) begin
              bounds.min_x = px;
              bounds.max_x = px;
              bounds.min_y = py;
              bounds.max_y = py;
              bounds.min_z = pz;
              bounds.max_z = pz;
            end else begin
              if (px < bounds.min_x) bounds.min_x = px;
              if (px > bounds.max_x) bounds.max_x = px;
              if (py < bounds.min_y) bounds.min_y = py;
              if (py > bounds.max_y) bounds.max_y = py;
              if (pz < bounds.min_z) bounds.min_z = pz;
              if (pz > bounds.max_z) bounds.max_z = pz;
            end
            if (s_axis_tlast_i) expected_boxes_q.push_back(box_result(bounds));
          end
          CMD_LOAD: begin
            bounds.min_x = px;
            bounds.min_y = py;
            bounds.min_z = pz;
            bounds.max_x = s_axis_tdata_i[3*CoordW +: CoordW];
            bounds.max_y = s_axis_tdata_i[4*CoordW +: CoordW];
            bounds.max_z = s_axis_tdata_i[5*CoordW +: CoordW];
            expected_boxes_q.push_back(box_result(bounds));
          end
          CMD_EMPTY: begin
            bounds = '0;
            expected_boxes_q.push_back(box_result(bounds));
          end
          default: ;
        endcase
      end

      // boxes still owed at the end count as failures
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (expected_boxes_q.size() != 0) begin
          fails += expected_boxes_q.size();
          $display("%0t: %0d expected results never arrived", $realtime,
                   expected_boxes_q.size());
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_boxes_q.size();
    results_o    <= results_seen;
  end

endmodule

// ===== dv/bounding_box_and_sphere_tb.sv =====
module bounding_box_and_sphere_tb;
  import bbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam logic [31:0] QMax       = 32'h7fff_ffff;
  localparam logic [31:0] QMin       = 32'h8000_0000;
  localparam logic [31:0] QOne       = 32'h0001_0000;
  localparam int          RandItems  = 1750;
  localparam int          HoldAfter  = 30;
  localparam int          HoldCycles = 400;
  localparam int          DrainWait  = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                drain = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  results;

  int n_points, n_loads, n_clears, n_unused;
  bit tx_calm, rx_calm;

  bounding_box_and_sphere uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bounding_box_and_sphere_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .drain_i         (drain),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [InDataW-1:0] pack_coords(
    input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
    input logic [31:0] ux, input logic [31:0] uy, input logic [31:0] uz);
    return {uz, uy, ux, z, y, x};
  endfunction

  // mix of extremes, full-range and near-origin values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return QMin;
      1:       return QMax;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h00c8_0000) - 32'h0064_0000;
    endcase
  endfunction

  function automatic logic [InDataW-1:0] rand_data();
    return pack_coords(rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
  endfunction

  // one input transfer after a random gap
  task automatic send_transfer(input logic [InDataW-1:0] data, input logic [1:0] cmd,
                               input logic first, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {first, cmd};
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    case (cmd)
      CMD_ADD:   n_points++;
      CMD_LOAD:  n_loads++;
      CMD_EMPTY: n_clears++;
      default:   n_unused++;
    endcase
  endtask

  // result side with random stalls and one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (taken == HoldAfter) stall = HoldCycles;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    int kind;
    int n;
    logic [31:0] lo, hi;
    logic [InDataW-1:0] box;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fold after reset without a first point
    send_transfer(pack_coords(5*QOne, -3*QOne, 7*QOne, 0, 0, 0), CMD_ADD, 1'b0, 1'b0);
    send_transfer(pack_coords(-QOne, 2*QOne, 0, QMax, QMin, 0), CMD_ADD, 1'b0, 1'b1);
    // single-point set
    send_transfer(pack_coords(QMax, QMin, 0, 0, 0, 0), CMD_ADD, 1'b1, 1'b1);
    // widest possible box
    send_transfer(pack_coords(QMin, QMin, QMin, 0, 0, 0), CMD_ADD, 1'b1, 1'b0);
    send_transfer(pack_coords(QMax, QMax, QMax, 0, 0, 0), CMD_ADD, 1'b0, 1'b1);
    // ordinary three-point set
    send_transfer(pack_coords(QOne, -QOne, 32'h1234_5678, 0, 0, 0), CMD_ADD, 1'b1, 1'b0);
    send_transfer(pack_coords(0, 0, 0, '1, '1, '1), CMD_ADD, 1'b0, 1'b0);
    send_transfer(pack_coords(-QOne, 3*QOne, -QOne, 0, 0, 0), CMD_ADD, 1'b0, 1'b1);
    // box loads, normal, reversed corners, full range
    send_transfer(pack_coords(-2*QOne, -2*QOne, -2*QOne, 3*QOne, 4*QOne, 12*QOne),
                  CMD_LOAD, 1'b0, 1'b0);
    send_transfer(pack_coords(QMax, QMax, QMax, QMin, QMin, QMin), CMD_LOAD, 1'b1, 1'b1);
    send_transfer(pack_coords(QMin, QMin, QMin, QMax, QMax, QMax), CMD_LOAD, 1'b0, 1'b1);
    // clears, then a fold into the cleared bounds
    send_transfer('0, CMD_EMPTY, 1'b0, 1'b0);
    send_transfer('1, CMD_EMPTY, 1'b1, 1'b1);
    send_transfer(pack_coords(QMin, QMax, 1, 0, 0, 0), CMD_ADD, 1'b0, 1'b1);
    // unused command code is ignored
    send_transfer('1, CmdUnused, 1'b1, 1'b1);
    send_transfer(pack_coords(7, -7, 0, '1, '1, '1), CMD_ADD, 1'b1, 1'b0);
    send_transfer('0, CmdUnused, 1'b0, 1'b0);
    send_transfer(pack_coords(-7, 7, QOne, 0, 0, 0), CMD_ADD, 1'b0, 1'b1);
    send_transfer(rand_data(), CMD_EMPTY, 1'b0, 1'b1);
    send_transfer('0, CMD_ADD, 1'b1, 1'b1);

    // random: mostly well-formed point sets, the rest loads, clears and noise
    while (n_points + n_loads + n_clears < RandItems + 19) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_transfer(rand_data(), CMD_ADD, i == 0, i == n - 1);
      end else if (kind < 77) begin
        lo  = rand_coord();
        hi  = rand_coord();
        box = rand_data();
        if ($urandom_range(0, 3) != 0 && $signed(hi) < $signed(lo)) begin
          box[0*32 +: 32] = hi;
          box[3*32 +: 32] = lo;
        end else begin
          box[0*32 +: 32] = lo;
          box[3*32 +: 32] = hi;
        end
        send_transfer(box, CMD_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind < 84) begin
        send_transfer(rand_data(), CMD_EMPTY, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else if (kind < 89) begin
        send_transfer(rand_data(), CmdUnused, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end else begin
        send_transfer(rand_data(), CMD_ADD, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    // drain outstanding results, then allow late extras to show up
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    drain <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("run covered %0d point, %0d load and %0d clear transfers, %0d unused codes",
             n_points, n_loads, n_clears, n_unused);
    $display("%0d results checked, including a %0d-cycle output hold-off", results,
             HoldCycles);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bbs_pkg.sv
rtl/core/bbs_front.sv
rtl/core/bbs_queue.sv
rtl/core/bbs_back.sv
rtl/core/bounding_box_and_sphere.sv
dv/bounding_box_and_sphere_checker.sv
dv/bounding_box_and_sphere_tb.sv
